// File: rtl/oupt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// oupt_pkg: shared types and constants for the oldest-user priority table
// Op codes, controller states and the command/status bundles between the
// sequencer and the datapath.
// ----------------------------------------------------------------------------
package oupt_pkg;

  localparam int unsigned DefCapacity = 16;
  localparam int unsigned DefIdBits   = 16;

  // Port field widths
  localparam int unsigned OP_W      = 2;
  localparam int unsigned USER_W    = 16;
  localparam int unsigned STAMP_W   = 63;
  localparam int unsigned COUNT_W   = 5;
  localparam int unsigned S_DATA_W  = 80;  // user + stamp, padded to bytes
  localparam int unsigned M_DATA_W  = 88;  // user + stamp + count, padded
  localparam int unsigned M_USER_W  = 2;   // removed_valid, full_error

  typedef enum logic [OP_W-1:0] {
    OP_ADD        = 2'd0,
    OP_UPDATE     = 2'd1,
    OP_ADD_NOTIME = 2'd2,
    OP_REMOVE     = 2'd3
  } op_e;

  // Table read address source
  typedef enum logic [1:0] {
    RD_IDX,
    RD_IDX_P1,
    RD_IDX_M1,
    RD_ZERO
  } rd_sel_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_POP_RD,
    ST_POP_CHK,
    ST_SHL_RD,
    ST_SHL_WR,
    ST_REF_RD,
    ST_REF_CHK,
    ST_INS,
    ST_FIND_RD,
    ST_FIND_CHK,
    ST_SHR,
    ST_SHR_WR,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic    load_item;
    logic    idx_clr;
    logic    idx_inc;
    logic    idx_dec;
    logic    idx_set_cnt;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    wr_en;
    logic    wr_new;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    pos_load;
    logic    cap_removed;
    logic    cap_pop;
    logic    ref_apply;
    logic    old_add;
    logic    set_full;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic idx_eq_cnt;
    logic idx_p1_ge_cnt;
    logic idx_eq_pos;
    logic cnt_zero;
    logic cnt_full;
    logic user_match;
    logic stamp_le;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

// File: rtl/oupt_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// oupt_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module oupt_ram #(
  parameter  int unsigned WIDTH  = 8,
  parameter  int unsigned DEPTH  = 16,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                  clk_i,
  input  wire logic                  we_i,
  input  wire logic [ADDR_W-1:0]     waddr_i,
  input  wire logic [WIDTH-1:0]      wdata_i,
  input  wire logic                  re_i,
  input  wire logic [ADDR_W-1:0]     raddr_i,
  output logic      [WIDTH-1:0]      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// File: rtl/oupt_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// oupt_ctrl: operation sequencer
// Walks the table one slot at a time: user search, ordered position search,
// shift down on removal, shift up on insert, oldest-stamp refresh.
// ----------------------------------------------------------------------------
module oupt_ctrl
  import oupt_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    s_tvalid_i,
  output logic         s_tready_o,
  input  wire status_t status_i,
  output cmd_t         cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_tvalid_i) state_d = ST_START;
      end
      ST_START: begin
        unique case (status_i.op)
          OP_REMOVE: state_d = ST_POP_RD;
          OP_UPDATE: state_d = ST_SCAN_RD;
          default:   state_d = ST_INS;
        endcase
      end
      ST_SCAN_RD:  state_d = status_i.idx_eq_cnt ? ST_INS : ST_SCAN_CHK;
      ST_SCAN_CHK: state_d = status_i.user_match ? ST_SHL_RD : ST_SCAN_RD;
      ST_POP_RD:   state_d = status_i.cnt_zero ? ST_DONE : ST_POP_CHK;
      ST_POP_CHK:  state_d = ST_SHL_RD;
      ST_SHL_RD:   state_d = status_i.idx_p1_ge_cnt ? ST_REF_RD : ST_SHL_WR;
      ST_SHL_WR:   state_d = ST_SHL_RD;
      ST_REF_RD:   state_d = ST_REF_CHK;
      ST_REF_CHK:  state_d = (status_i.op == OP_REMOVE) ? ST_DONE : ST_INS;
      ST_INS:      state_d = status_i.cnt_full ? ST_DONE : ST_FIND_RD;
      ST_FIND_RD:  state_d = status_i.idx_eq_cnt ? ST_SHR : ST_FIND_CHK;
      ST_FIND_CHK: state_d = status_i.stamp_le ? ST_FIND_RD : ST_SHR;
      ST_SHR:      state_d = status_i.idx_eq_pos ? ST_DONE : ST_SHR_WR;
      ST_SHR_WR:   state_d = ST_SHR;
      ST_DONE: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default:     state_d = ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o        = '0;
    cmd_o.rd_sel = RD_IDX;
    s_tready_o   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          cmd_o.load_item = 1'b1;
          cmd_o.idx_clr   = 1'b1;
        end
      end
      ST_START: ;
      ST_SCAN_RD: begin
        if (!status_i.idx_eq_cnt) cmd_o.rd_en = 1'b1;
      end
      ST_SCAN_CHK: begin
        if (status_i.user_match) cmd_o.cap_removed = 1'b1;
        else                     cmd_o.idx_inc     = 1'b1;
      end
      ST_POP_RD: begin
        if (!status_i.cnt_zero) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_ZERO;
        end
      end
      ST_POP_CHK: begin
        cmd_o.cap_removed = 1'b1;
        cmd_o.cap_pop     = 1'b1;
      end
      ST_SHL_RD: begin
        if (status_i.idx_p1_ge_cnt) begin
          cmd_o.cnt_dec = 1'b1;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_IDX_P1;
        end
      end
      ST_SHL_WR: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.idx_inc = 1'b1;
      end
      ST_REF_RD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_ZERO;
      end
      ST_REF_CHK: cmd_o.ref_apply = 1'b1;
      ST_INS: begin
        if (status_i.cnt_full) cmd_o.set_full = 1'b1;
        else                   cmd_o.idx_clr  = 1'b1;
      end
      ST_FIND_RD: begin
        if (status_i.idx_eq_cnt) begin
          cmd_o.pos_load    = 1'b1;
          cmd_o.idx_set_cnt = 1'b1;
        end else begin
          cmd_o.rd_en = 1'b1;
        end
      end
      ST_FIND_CHK: begin
        if (status_i.stamp_le) begin
          cmd_o.idx_inc = 1'b1;
        end else begin
          cmd_o.pos_load    = 1'b1;
          cmd_o.idx_set_cnt = 1'b1;
        end
      end
      ST_SHR: begin
        if (status_i.idx_eq_pos) begin
          cmd_o.wr_en   = 1'b1;
          cmd_o.wr_new  = 1'b1;
          cmd_o.cnt_inc = 1'b1;
          cmd_o.old_add = 1'b1;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_IDX_M1;
        end
      end
      ST_SHR_WR: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.idx_dec = 1'b1;
      end
      ST_DONE: begin
        if (status_i.out_free) cmd_o.out_load = 1'b1;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/oupt_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// oupt_dp: table datapath
// Slot RAM, walk index, insert position, fill count, oldest-stamp tracking
// and the result register.
// ----------------------------------------------------------------------------
module oupt_dp
  import oupt_pkg::*;
#(
  parameter int unsigned CAPACITY = DefCapacity,
  parameter int unsigned ID_BITS  = DefIdBits
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire cmd_t                  cmd_i,
  output status_t                    status_o,
  input  wire logic [S_DATA_W-1:0]   s_tdata_i,
  input  wire logic [OP_W-1:0]       s_tuser_i,
  output logic                       m_tvalid_o,
  input  wire logic                  m_tready_i,
  output logic      [M_DATA_W-1:0]   m_tdata_o,
  output logic      [M_USER_W-1:0]   m_tuser_o
);

  localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
  localparam int unsigned ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned ENT_W  = ID_BITS + STAMP_W;

  // Item and control state
  op_e                op_q;
  logic [CNT_W-1:0]   idx_q, pos_q, count_q;
  logic [STAMP_W-1:0] oldest_q;
  logic               rm_valid_q, full_q, out_valid_q;

  // Payload
  logic [ID_BITS-1:0] user_q, rm_user_q;
  logic [STAMP_W-1:0] stamp_q, removed_q;
  logic [M_DATA_W-1:0] out_data_q;
  logic [M_USER_W-1:0] out_user_q;

  logic [USER_W-1:0]  in_user;
  logic [STAMP_W-1:0] in_stamp;
  op_e                in_op;

  logic [CNT_W-1:0]   rd_idx;
  logic [ENT_W-1:0]   rdata, wdata;
  logic [ID_BITS-1:0] rd_user;
  logic [STAMP_W-1:0] rd_stamp;

  assign in_user  = s_tdata_i[USER_W-1:0];
  assign in_stamp = s_tdata_i[USER_W +: STAMP_W];
  assign in_op    = op_e'(s_tuser_i);

  assign rd_user  = rdata[ID_BITS-1:0];
  assign rd_stamp = rdata[ID_BITS +: STAMP_W];

  always_comb begin
    unique case (cmd_i.rd_sel)
      RD_IDX:    rd_idx = idx_q;
      RD_IDX_P1: rd_idx = idx_q + CNT_W'(1);
      RD_IDX_M1: rd_idx = idx_q - CNT_W'(1);
      RD_ZERO:   rd_idx = '0;
      default:   rd_idx = idx_q;
    endcase
  end

  assign wdata = cmd_i.wr_new ? {stamp_q, user_q} : rdata;

  oupt_ram #(
    .WIDTH (ENT_W),
    .DEPTH (CAPACITY)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_en),
    .waddr_i (idx_q[ADDR_W-1:0]),
    .wdata_i (wdata),
    .re_i    (cmd_i.rd_en),
    .raddr_i (rd_idx[ADDR_W-1:0]),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q        <= OP_ADD;
      idx_q       <= '0;
      pos_q       <= '0;
      count_q     <= '0;
      oldest_q    <= '0;
      rm_valid_q  <= 1'b0;
      full_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load_item) begin
        op_q       <= in_op;
        rm_valid_q <= 1'b0;
        full_q     <= 1'b0;
      end
      if (cmd_i.cap_pop)  rm_valid_q <= 1'b1;
      if (cmd_i.set_full) full_q     <= 1'b1;

      priority if (cmd_i.idx_clr)     idx_q <= '0;
      else if (cmd_i.idx_inc)         idx_q <= idx_q + CNT_W'(1);
      else if (cmd_i.idx_dec)         idx_q <= idx_q - CNT_W'(1);
      else if (cmd_i.idx_set_cnt)     idx_q <= count_q;
      else                            idx_q <= idx_q;

      if (cmd_i.pos_load) pos_q <= idx_q;

      if (cmd_i.cnt_inc)      count_q <= count_q + CNT_W'(1);
      else if (cmd_i.cnt_dec) count_q <= count_q - CNT_W'(1);

      // Refresh after removal uses the new head, read after the shift
      if (cmd_i.ref_apply && (oldest_q == removed_q)) begin
        oldest_q <= (count_q == '0) ? '0 : rd_stamp;
      end else if (cmd_i.old_add && (op_q != OP_ADD_NOTIME) &&
                   ((oldest_q > stamp_q) || (oldest_q == '0))) begin
        oldest_q <= stamp_q;
      end

      if (cmd_i.out_load)     out_valid_q <= 1'b1;
      else if (m_tready_i)    out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      user_q    <= ID_BITS'(in_user);
      // add without time inserts a null stamp
      stamp_q   <= (in_op == OP_ADD_NOTIME) ? '0 : in_stamp;
      rm_user_q <= '0;
    end
    if (cmd_i.cap_pop)     rm_user_q <= rd_user;
    if (cmd_i.cap_removed) removed_q <= rd_stamp;
    if (cmd_i.out_load) begin
      out_data_q <= M_DATA_W'({COUNT_W'(count_q), oldest_q, USER_W'(rm_user_q)});
      out_user_q <= {full_q, rm_valid_q};
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_data_q;
  assign m_tuser_o  = out_user_q;

  always_comb begin
    status_o.op            = op_q;
    status_o.idx_eq_cnt    = (idx_q == count_q);
    status_o.idx_p1_ge_cnt = (({1'b0, idx_q} + (CNT_W + 1)'(1)) >= {1'b0, count_q});
    status_o.idx_eq_pos    = (idx_q == pos_q);
    status_o.cnt_zero      = (count_q == '0);
    status_o.cnt_full      = (count_q == CNT_W'(CAPACITY));
    status_o.user_match    = (rd_user == user_q);
    status_o.stamp_le      = (rd_stamp <= stamp_q);
    status_o.out_free      = !out_valid_q || m_tready_i;
  end

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("fill count above capacity");

  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr_en |-> (idx_q < CNT_W'(CAPACITY)) && (idx_q <= count_q))
    else $error("table write outside held slots");

  a_full_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.set_full |-> (count_q == CNT_W'(CAPACITY)))
    else $error("insert dropped while table has room");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cap_pop |-> (count_q != '0) && $past(cmd_i.rd_en))
    else $error("pop without a head read");

endmodule
`default_nettype wire

// File: rtl/oldest_user_priority_table_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// oldest_user_priority_table_top: ordered table of (user id, timestamp)
// Add, update, add-without-time and remove-oldest on a stamp-ordered table,
// tracking the oldest known timestamp.
// ----------------------------------------------------------------------------
// One item is handled at a time. The slot RAM has one read port with
// registered data, so each slot step is a read followed by a compare or a
// write. Remove oldest pops the head and closes the gap, add finds the
// ordered position and shifts the later entries up, update searches for the
// user, closes its gap if found and reinserts, and an insert on a full table
// is dropped and flagged as full_error. The result register lets the next
// item be accepted while a result waits; a later result stalls until it drains.
// ----------------------------------------------------------------------------
module oldest_user_priority_table_top
  import oupt_pkg::*;
#(
  parameter int unsigned CAPACITY = DefCapacity,
  parameter int unsigned ID_BITS  = DefIdBits
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  // [15:0] user_id, [78:16] stamp, [79] zero
  input  wire logic [S_DATA_W-1:0]  s_axis_tdata_i,
  // [1:0] op
  input  wire logic [OP_W-1:0]      s_axis_tuser_i,
  output logic                      m_axis_tvalid_o,
  input  wire logic                 m_axis_tready_i,
  // [15:0] removed_user, [78:16] oldest_stamp, [83:79] entry_count, [87:84] zero
  output logic      [M_DATA_W-1:0]  m_axis_tdata_o,
  // [0] removed_valid, [1] full_error
  output logic      [M_USER_W-1:0]  m_axis_tuser_o
);

  cmd_t    cmd;
  status_t status;

  oupt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  oupt_dp #(
    .CAPACITY (CAPACITY),
    .ID_BITS  (ID_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .s_tdata_i  (s_axis_tdata_i),
    .s_tuser_i  (s_axis_tuser_i),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .m_tdata_o  (m_axis_tdata_o),
    .m_tuser_o  (m_axis_tuser_o)
  );

endmodule
`default_nettype wire
